FILE: hw/rtl/vvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vvs_pkg;

  // Field and arithmetic widths
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 24;
  localparam int FRAC_BITS      = 16;
  localparam int LEN_BITS       = 3;
  localparam int COUNT_BITS     = 2;
  localparam int SCALAR_BITS    = 32;
  localparam int MUL_B_BITS     = (COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS;
  localparam int PROD_BITS      = SAMPLE_BITS + MUL_B_BITS;
  localparam int ACC_BITS       = PROD_BITS + 4;
  localparam int RES_BITS       = ACC_BITS + 1;
  localparam int ROOT_BITS      = (ACC_BITS + 1) / 2;
  localparam int ITER_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS       = ROOT_BITS + 3;
  localparam int STEP_BITS      = $clog2(ITER_BITS + 1);

  // Port widths
  localparam int S_TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS   = ((SCALAR_BITS + 7) / 8) * 8;
  localparam int M_TUSER_BITS   = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COEF_BITS;

  // Vector length limits
  localparam logic [LEN_BITS-1:0] LEN_MIN  = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_MAX  = LEN_BITS'(4);
  localparam logic [LEN_BITS-1:0] LEN_GREY = LEN_BITS'(3);
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(3);

  // Clip limits of the signed 32-bit result
  localparam logic signed [RES_BITS-1:0] SCALAR_MAX =
    {{(RES_BITS-SCALAR_BITS+1){1'b0}}, {(SCALAR_BITS-1){1'b1}}};
  localparam logic signed [RES_BITS-1:0] SCALAR_MIN = ~SCALAR_MAX;
  localparam logic signed [RES_BITS-1:0] SAT_HIGH   = SCALAR_MAX + RES_BITS'(1);

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE       = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH     = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ZERO  = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ONE   = CFG_INDEX_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_TWO   = CFG_INDEX_BITS'(4);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_THREE = CFG_INDEX_BITS'(5);

  typedef enum logic [1:0] {
    MODE_MAG  = 2'd0,
    MODE_AVG  = 2'd1,
    MODE_GREY = 2'd2,
    MODE_LIN  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PASS,
    ST_FIN,
    ST_ITER,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic pass;
    logic finish;
    logic take_iter;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_one;
    logic voxel_end;
    logic iter_needed;
    logic iter_busy;
    logic out_free;
  } status_t;

  // Luma weights in Q8.16 (0.299, 0.587, 0.114); no weight for a fourth component
  function automatic logic signed [MUL_B_BITS-1:0] grey_weight(input logic [COUNT_BITS-1:0] idx);
    logic signed [MUL_B_BITS-1:0] w;
    unique case (idx)
      2'd0:    w = MUL_B_BITS'(19595);
      2'd1:    w = MUL_B_BITS'(38470);
      2'd2:    w = MUL_B_BITS'(7471);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vvs_iter.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared iterative unit: restoring square root (two bits per cycle) or
// restoring divide by a small length (one quotient bit per cycle).
module vvs_iter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           is_div,
  input  logic [vvs_pkg::ITER_BITS-1:0]  operand,
  input  logic [vvs_pkg::LEN_BITS-1:0]   divisor,
  output logic                           busy,
  output logic [vvs_pkg::ITER_BITS-1:0]  result
);

  logic                            div_mode;
  logic [vvs_pkg::STEP_BITS-1:0]   steps;
  logic [vvs_pkg::ITER_BITS-1:0]   shreg;
  logic [vvs_pkg::REM_BITS-1:0]    rem;
  logic [vvs_pkg::ROOT_BITS-1:0]   root;
  logic [vvs_pkg::LEN_BITS-1:0]    dvs;

  logic [vvs_pkg::REM_BITS-1:0]    sq_rem_sh;
  logic [vvs_pkg::REM_BITS-1:0]    sq_trial;
  logic                            sq_fit;
  logic [vvs_pkg::REM_BITS-1:0]    dv_rem_sh;
  logic                            dv_fit;

  // Form trial remainders for one step
  always_comb begin
    sq_rem_sh = {rem[vvs_pkg::REM_BITS-3:0], shreg[vvs_pkg::ITER_BITS-1 -: 2]};
    sq_trial  = vvs_pkg::REM_BITS'({root, 2'b01});
    sq_fit    = sq_rem_sh >= sq_trial;
    dv_rem_sh = {rem[vvs_pkg::REM_BITS-2:0], shreg[vvs_pkg::ITER_BITS-1]};
    dv_fit    = dv_rem_sh >= vvs_pkg::REM_BITS'(dvs);
  end

  // Load on start, then advance one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      div_mode <= is_div;
      steps    <= is_div ? vvs_pkg::STEP_BITS'(vvs_pkg::ITER_BITS)
                         : vvs_pkg::STEP_BITS'(vvs_pkg::ROOT_BITS);
      shreg    <= operand;
      rem      <= '0;
      root     <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (div_mode) begin
        rem   <= dv_fit ? dv_rem_sh - vvs_pkg::REM_BITS'(dvs) : dv_rem_sh;
        shreg <= {shreg[vvs_pkg::ITER_BITS-2:0], dv_fit};
      end else begin
        rem   <= sq_fit ? sq_rem_sh - sq_trial : sq_rem_sh;
        root  <= {root[vvs_pkg::ROOT_BITS-2:0], sq_fit};
        shreg <= shreg << 2;
      end
      steps <= steps - vvs_pkg::STEP_BITS'(1);
      if (steps == vvs_pkg::STEP_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign result = div_mode ? shreg : vvs_pkg::ITER_BITS'(root);

endmodule

`default_nettype wire

FILE: hw/rtl/vvs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers, multiply-accumulate, finish logic and output word.
module vvs_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [vvs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vvs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [vvs_pkg::SAMPLE_BITS-1:0]     in_component,
  input  logic                                in_invalid,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [vvs_pkg::SCALAR_BITS-1:0]     out_scalar,
  output logic                                out_invalid,
  output logic                                out_saturated,
  output logic                                out_config_error,
  input  vvs_pkg::cmd_t                       cmd,
  output vvs_pkg::status_t                    st
);

  vvs_pkg::mode_t                         mode;
  logic [vvs_pkg::LEN_BITS-1:0]           len_raw;
  logic signed [vvs_pkg::COEF_BITS-1:0]   coef [4];

  logic [vvs_pkg::LEN_BITS-1:0]           len_eff;
  logic signed [vvs_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   inv_in;
  logic signed [vvs_pkg::MUL_B_BITS-1:0]  mul_b;
  logic signed [vvs_pkg::PROD_BITS-1:0]   prod;
  logic signed [vvs_pkg::ACC_BITS-1:0]    acc;
  logic [vvs_pkg::COUNT_BITS-1:0]         count;
  logic                                   inv_seen;

  logic                                   cerr_now;
  logic                                   bad_now;
  logic                                   iter_start;
  logic [vvs_pkg::ACC_BITS-1:0]           acc_mag;
  logic [vvs_pkg::ITER_BITS-1:0]          iter_operand;
  logic                                   iter_busy;
  logic [vvs_pkg::ITER_BITS-1:0]          iter_result;
  logic signed [vvs_pkg::RES_BITS-1:0]    iter_mag;

  logic signed [vvs_pkg::RES_BITS-1:0]    res;
  logic                                   res_neg;
  logic                                   bad;
  logic                                   cerr;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= vvs_pkg::MODE_MAG;
      len_raw <= vvs_pkg::LEN_RESET;
      for (int i = 0; i < 4; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vvs_pkg::REG_MODE:       mode    <= vvs_pkg::mode_t'(cfg_data[1:0]);
        vvs_pkg::REG_LENGTH:     len_raw <= cfg_data[vvs_pkg::LEN_BITS-1:0];
        vvs_pkg::REG_COEF_ZERO:  coef[0] <= cfg_data[vvs_pkg::COEF_BITS-1:0];
        vvs_pkg::REG_COEF_ONE:   coef[1] <= cfg_data[vvs_pkg::COEF_BITS-1:0];
        vvs_pkg::REG_COEF_TWO:   coef[2] <= cfg_data[vvs_pkg::COEF_BITS-1:0];
        vvs_pkg::REG_COEF_THREE: coef[3] <= cfg_data[vvs_pkg::COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length register to one through four
  always_comb begin
    if (len_raw < vvs_pkg::LEN_MIN) begin
      len_eff = vvs_pkg::LEN_MIN;
    end else if (len_raw > vvs_pkg::LEN_MAX) begin
      len_eff = vvs_pkg::LEN_MAX;
    end else begin
      len_eff = len_raw;
    end
  end

  // Pick the second multiplier operand by mode
  always_comb begin
    unique case (mode)
      vvs_pkg::MODE_MAG:  mul_b = vvs_pkg::MUL_B_BITS'(sample);
      vvs_pkg::MODE_AVG:  mul_b = vvs_pkg::MUL_B_BITS'(1);
      vvs_pkg::MODE_GREY: mul_b = vvs_pkg::grey_weight(count);
      default:            mul_b = vvs_pkg::MUL_B_BITS'(coef[count]);
    endcase
  end

  // Finish decisions
  always_comb begin
    cerr_now     = (mode == vvs_pkg::MODE_GREY) && (len_eff != vvs_pkg::LEN_GREY);
    bad_now      = inv_seen || cerr_now;
    acc_mag      = acc[vvs_pkg::ACC_BITS-1] ? vvs_pkg::ACC_BITS'(-acc)
                                            : vvs_pkg::ACC_BITS'(acc);
    iter_operand = (mode == vvs_pkg::MODE_MAG) ? vvs_pkg::ITER_BITS'(acc_mag)
                                               : vvs_pkg::ITER_BITS'(acc_mag);
    iter_mag     = vvs_pkg::RES_BITS'(iter_result);
  end

  assign st.len_one     = (len_eff == vvs_pkg::LEN_MIN);
  assign st.voxel_end   = (vvs_pkg::LEN_BITS'(count) + vvs_pkg::LEN_BITS'(1)) >= len_eff;
  assign st.iter_needed = !bad_now &&
                          (((mode == vvs_pkg::MODE_MAG) && !acc[vvs_pkg::ACC_BITS-1]) ||
                           (mode == vvs_pkg::MODE_AVG));
  assign st.iter_busy   = iter_busy;
  assign st.out_free    = !out_valid || out_ready;
  assign iter_start     = cmd.finish && st.iter_needed;

  // Capture the word, multiply, accumulate, and close the voxel
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      count    <= '0;
      inv_seen <= 1'b0;
    end else begin
      if (cmd.capture) begin
        sample <= in_component;
        inv_in <= in_invalid;
      end
      if (cmd.mul) begin
        prod <= sample * mul_b;
      end
      if (cmd.acc) begin
        acc      <= acc + vvs_pkg::ACC_BITS'(prod);
        count    <= count + vvs_pkg::COUNT_BITS'(1);
        inv_seen <= inv_seen || inv_in;
      end
      if (cmd.finish) begin
        bad     <= bad_now;
        cerr    <= cerr_now;
        res_neg <= acc[vvs_pkg::ACC_BITS-1];
        // Negative sum of squares only arises from a mode change; its root clips high
        res     <= (mode == vvs_pkg::MODE_MAG) ? vvs_pkg::SAT_HIGH
                 : vvs_pkg::RES_BITS'(acc >>> vvs_pkg::FRAC_BITS);
        acc      <= '0;
        count    <= '0;
        inv_seen <= 1'b0;
      end
      if (cmd.pass) begin
        bad      <= inv_in;
        cerr     <= 1'b0;
        res      <= vvs_pkg::RES_BITS'(sample);
        acc      <= '0;
        count    <= '0;
        inv_seen <= 1'b0;
      end
      if (cmd.take_iter) begin
        res <= res_neg ? -iter_mag : iter_mag;
      end
    end
  end

  vvs_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .start   (iter_start),
    .is_div  (mode == vvs_pkg::MODE_AVG),
    .operand (iter_operand),
    .divisor (len_eff),
    .busy    (iter_busy),
    .result  (iter_result)
  );

  // Output word: clip to 32 bits, zero invalid results
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_config_error <= cerr;
      if (bad) begin
        out_scalar    <= '0;
        out_invalid   <= 1'b1;
        out_saturated <= 1'b0;
      end else if (res > vvs_pkg::SCALAR_MAX) begin
        out_scalar    <= vvs_pkg::SCALAR_MAX[vvs_pkg::SCALAR_BITS-1:0];
        out_invalid   <= 1'b0;
        out_saturated <= 1'b1;
      end else if (res < vvs_pkg::SCALAR_MIN) begin
        out_scalar    <= vvs_pkg::SCALAR_MIN[vvs_pkg::SCALAR_BITS-1:0];
        out_invalid   <= 1'b0;
        out_saturated <= 1'b1;
      end else begin
        out_scalar    <= res[vvs_pkg::SCALAR_BITS-1:0];
        out_invalid   <= 1'b0;
        out_saturated <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vvs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: one component through multiply and accumulate, then voxel finish.
module vvs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vvs_pkg::status_t  st,
  output vvs_pkg::cmd_t     cmd
);

  vvs_pkg::state_t state;
  vvs_pkg::state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance and issue commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      vvs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = st.len_one ? vvs_pkg::ST_PASS : vvs_pkg::ST_MUL;
        end
      end
      vvs_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = vvs_pkg::ST_ACC;
      end
      vvs_pkg::ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = st.voxel_end ? vvs_pkg::ST_FIN : vvs_pkg::ST_IDLE;
      end
      vvs_pkg::ST_PASS: begin
        cmd.pass   = 1'b1;
        state_next = vvs_pkg::ST_DONE;
      end
      vvs_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = st.iter_needed ? vvs_pkg::ST_ITER : vvs_pkg::ST_DONE;
      end
      vvs_pkg::ST_ITER: begin
        if (!st.iter_busy) begin
          cmd.take_iter = 1'b1;
          state_next    = vvs_pkg::ST_DONE;
        end
      end
      vvs_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = vvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vvs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vector_voxel_to_scalar_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Reduces each voxel's vector of signed components, one word per component, to one
// scalar word: magnitude (floor square root of the sum of squares), average
// (truncated toward zero), grey (fixed luma weights, Q8.16, floored) or a linear
// combination with four Q8.16 coefficient registers. A vector length of one passes
// each component through. A component goes through accept, multiply and
// accumulate on the single multiplier. Closing a voxel then runs a finish step;
// magnitude goes on through the square root unit (two bits a cycle) and average
// through the divider (one quotient bit a cycle), both on one shared iterative
// unit. The result is then loaded into the output register. A finished
// word waits in that register while the next component is taken in. The
// configuration port is always ready; write it only while no voxel is in flight.
module vector_voxel_to_scalar_core (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vvs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vvs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // Component stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [vvs_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,   // [15:0] component
  input  logic [0:0]                          s_axis_tuser,   // [0] component_invalid
  // Scalar stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [vvs_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,   // [31:0] scalar
  output logic [vvs_pkg::M_TUSER_BITS-1:0]    m_axis_tuser    // [0] result_invalid,
                                                              // [1] saturated,
                                                              // [2] config_error
);

  vvs_pkg::cmd_t    ctl_cmd;
  vvs_pkg::status_t dp_st;
  logic [vvs_pkg::SCALAR_BITS-1:0] scalar;

  assign cfg_ready = 1'b1;

  vvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (dp_st),
    .cmd      (ctl_cmd)
  );

  vvs_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_component     (s_axis_tdata[vvs_pkg::SAMPLE_BITS-1:0]),
    .in_invalid       (s_axis_tuser[0]),
    .out_ready        (m_axis_tready),
    .out_valid        (m_axis_tvalid),
    .out_scalar       (scalar),
    .out_invalid      (m_axis_tuser[0]),
    .out_saturated    (m_axis_tuser[1]),
    .out_config_error (m_axis_tuser[2]),
    .cmd              (ctl_cmd),
    .st               (dp_st)
  );

  assign m_axis_tdata = vvs_pkg::M_TDATA_BITS'(scalar);

  // Never overwrite a word that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.load_out |-> dp_st.out_free)
    else $error("output word overwritten before it was taken");

  // Never restart the iterative unit while it runs
  a_iter_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl_cmd.finish && dp_st.iter_needed) |-> !dp_st.iter_busy)
    else $error("iterative unit restarted while busy");

  // Invalid results carry zero and no saturation
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> ((m_axis_tdata == '0) && !m_axis_tuser[1]))
    else $error("invalid result with nonzero value or saturation");

  // A configuration error always marks the result invalid
  a_cerr_invalid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[0])
    else $error("configuration error without invalid flag");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import vvs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 500;

  // Luma weights in Q8.16
  localparam longint LUMA_R = 19595;
  localparam longint LUMA_G = 38470;
  localparam longint LUMA_B = 7471;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] amplitude;
    logic                          marked_bad;
  } comp_word_t;

  typedef struct {
    logic signed [SCALAR_BITS-1:0] scalar;
    logic                          invalid;
    logic                          clipped;
    logic                          cfg_err;
  } scalar_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_data = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [S_TDATA_BITS-1:0]     s_axis_tdata = '0;   // [15:0] component
  logic [0:0]                  s_axis_tuser = '0;   // [0] component_invalid
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [M_TDATA_BITS-1:0]     m_axis_tdata;        // [31:0] scalar
  logic [M_TUSER_BITS-1:0]     m_axis_tuser;        // [0] result_invalid, [1] saturated,
                                                    // [2] config_error

  vector_voxel_to_scalar_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Mirror of the block's registers and voxel state
  mode_t                       mode_r = MODE_MAG;
  logic [LEN_BITS-1:0]         len_r = 3'd3;
  logic signed [COEF_BITS-1:0] coef_r [4] = '{default: '0};
  longint                      voxel_sum = 0;
  int                          voxel_taken = 0;
  logic                        voxel_bad = 1'b0;

  comp_word_t   comp_queue [$];
  scalar_word_t scalar_due [$];

  int errors = 0;
  int comps_taken = 0;
  int words_seen = 0;
  int reg_writes = 0;
  int settings_run = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int ready_left = 0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int eff_len(input logic [LEN_BITS-1:0] l);
    if (l == 0) return 1;
    if (l > 4) return 4;
    return int'(l);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root, bitv, rem;
    root = '0;
    rem  = x;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Fold one accepted component into the voxel; queue a word when the voxel closes
  task automatic reduce_component(input comp_word_t cw);
    int           eff;
    longint       s, r;
    logic         cerr, bad;
    scalar_word_t w;
    eff = eff_len(len_r);
    s   = cw.amplitude;
    w   = '{scalar: '0, invalid: 1'b0, clipped: 1'b0, cfg_err: 1'b0};
    if (eff == 1) begin
      voxel_sum   = 0;
      voxel_taken = 0;
      voxel_bad   = 1'b0;
      if (cw.marked_bad) w.invalid = 1'b1;
      else w.scalar = s[31:0];
      scalar_due.push_back(w);
      return;
    end
    if (cw.marked_bad) voxel_bad = 1'b1;
    case (mode_r)
      MODE_MAG: voxel_sum += s * s;
      MODE_AVG: voxel_sum += s;
      MODE_GREY: begin
        if (voxel_taken == 0) voxel_sum += LUMA_R * s;
        else if (voxel_taken == 1) voxel_sum += LUMA_G * s;
        else if (voxel_taken == 2) voxel_sum += LUMA_B * s;
      end
      default: voxel_sum += longint'(coef_r[voxel_taken]) * s;
    endcase
    voxel_taken++;
    if (voxel_taken < eff) return;
    // Close the voxel
    cerr = (mode_r == MODE_GREY) && (eff != 3);
    bad  = voxel_bad || cerr;
    r    = 0;
    if (!bad) begin
      case (mode_r)
        MODE_MAG: r = longint'(int_sqrt(voxel_sum));
        MODE_AVG: r = voxel_sum / longint'(eff);
        default:  r = voxel_sum >>> FRAC_BITS;
      endcase
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        w.clipped = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        w.clipped = 1'b1;
      end
      w.scalar = r[31:0];
    end
    w.invalid = bad;
    w.cfg_err = cerr;
    scalar_due.push_back(w);
    voxel_sum   = 0;
    voxel_taken = 0;
    voxel_bad   = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:       mode_r = mode_t'(val[1:0]);
      REG_LENGTH:     len_r = val[LEN_BITS-1:0];
      REG_COEF_ZERO:  coef_r[0] = val;
      REG_COEF_ONE:   coef_r[1] = val;
      REG_COEF_TWO:   coef_r[2] = val;
      REG_COEF_THREE: coef_r[3] = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic push_comp(input logic signed [SAMPLE_BITS-1:0] a, input logic b);
    comp_word_t cw;
    cw.amplitude  = a;
    cw.marked_bad = b;
    comp_queue.push_back(cw);
  endtask

  // Hold off until every word has come back, then let the block settle
  task automatic drain();
    while (comp_queue.size() != 0 || scalar_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settings_run++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'd65536;
      3:       return 24'($urandom_range(0, 131072)) - 24'd65536;
      default: return 24'($urandom());
    endcase
  endfunction

  // Component driver: bursts of random length, random gaps between them
  always @(posedge clk) begin : comp_driver
    logic nv;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        reduce_component(comp_queue.pop_front());
        comps_taken++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else if (!s_axis_tvalid && gap_left > 0) begin
        gap_left--;
      end
      nv = (gap_left == 0) && (comp_queue.size() != 0);
      s_axis_tvalid <= nv;
      if (nv) begin
        s_axis_tdata <= comp_queue[0].amplitude;
        s_axis_tuser <= comp_queue[0].marked_bad;
      end
    end
  end

  // Scalar receiver: ready held for random stretches, with occasional long stalls
  always @(posedge clk) begin : scalar_sink
    if (ready_left > 0) begin
      ready_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          m_axis_tready <= 1'b1;
          ready_left = $urandom_range(1, 40);
        end
        4, 5, 6: begin
          m_axis_tready <= 1'b0;
          ready_left = $urandom_range(1, 6);
        end
        7, 8: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
          ready_left = 0;
        end
        default: begin
          m_axis_tready <= 1'b0;
          ready_left = $urandom_range(20, 30);
        end
      endcase
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin : scalar_check
    scalar_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (scalar_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word scalar=%0d tuser=%b",
                                $signed(m_axis_tdata[31:0]), m_axis_tuser));
      end else begin
        want = scalar_due.pop_front();
        if (m_axis_tdata[31:0] !== want.scalar)
          flag_mismatch($sformatf("word %0d scalar got %0d want %0d", words_seen,
                                  $signed(m_axis_tdata[31:0]), want.scalar));
        if (m_axis_tuser[0] !== want.invalid)
          flag_mismatch($sformatf("word %0d result_invalid got %b want %b", words_seen,
                                  m_axis_tuser[0], want.invalid));
        if (m_axis_tuser[1] !== want.clipped)
          flag_mismatch($sformatf("word %0d saturated got %b want %b", words_seen,
                                  m_axis_tuser[1], want.clipped));
        if (m_axis_tuser[2] !== want.cfg_err)
          flag_mismatch($sformatf("word %0d config_error got %b want %b", words_seen,
                                  m_axis_tuser[2], want.cfg_err));
      end
    end
  end

  // Abort on a hang
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    mode_t               m;
    logic [LEN_BITS-1:0] l;
    int                  eff, voxels, random_comps;
    random_comps = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Magnitude at reset settings: extremes, then a voxel with an invalid component
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh7FFF, 1'b0);
    push_comp(16'sd5, 1'b1);
    push_comp(16'sh7FFF, 1'b0);
    drain();

    // Average over four, negative sum truncates toward zero
    write_reg(REG_MODE, 24'(MODE_AVG));
    write_reg(REG_LENGTH, 24'd4);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh8001, 1'b0);
    drain();

    // Grey with three components
    write_reg(REG_MODE, 24'(MODE_GREY));
    write_reg(REG_LENGTH, 24'd3);
    push_comp(16'sh7FFF, 1'b0);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh7FFF, 1'b0);
    drain();

    // Grey with a bad length still consumes the voxel
    write_reg(REG_LENGTH, 24'd2);
    push_comp(16'sd100, 1'b0);
    push_comp(-16'sd100, 1'b0);
    drain();

    // Linear with extreme coefficients
    write_reg(REG_MODE, 24'(MODE_LIN));
    write_reg(REG_LENGTH, 24'd4);
    write_reg(REG_COEF_ZERO, 24'h7FFFFF);
    write_reg(REG_COEF_ONE, 24'h800000);
    write_reg(REG_COEF_TWO, 24'h7FFFFF);
    write_reg(REG_COEF_THREE, 24'h800000);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh7FFF, 1'b0);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh7FFF, 1'b0);
    drain();

    // Passthrough in grey mode, then length zero treated as one
    write_reg(REG_MODE, 24'(MODE_GREY));
    write_reg(REG_LENGTH, 24'd1);
    push_comp(16'sh8000, 1'b0);
    push_comp(16'sh7FFF, 1'b1);
    drain();
    write_reg(REG_LENGTH, 24'd0);
    push_comp(16'sh7FFF, 1'b0);
    drain();

    // Length above four clamps to four
    write_reg(REG_MODE, 24'(MODE_AVG));
    write_reg(REG_LENGTH, 24'd6);
    push_comp(16'sh7FFF, 1'b0);
    push_comp(16'sh7FFF, 1'b0);
    push_comp(16'sh7FFF, 1'b0);
    push_comp(16'sh7FFE, 1'b0);
    drain();

    // Random settings, whole voxels of random content per setting
    while (random_comps < RANDOM_ITEMS) begin
      m = mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 11))
        0:       l = '0;
        1:       l = LEN_BITS'($urandom_range(5, 7));
        default: l = LEN_BITS'($urandom_range(1, 4));
      endcase
      write_reg(REG_MODE, 24'(m));
      write_reg(REG_LENGTH, 24'(l));
      if (m == MODE_LIN) begin
        write_reg(REG_COEF_ZERO, pick_coef());
        write_reg(REG_COEF_ONE, pick_coef());
        write_reg(REG_COEF_TWO, pick_coef());
        write_reg(REG_COEF_THREE, pick_coef());
      end
      eff    = eff_len(l);
      voxels = $urandom_range(3, 15);
      for (int v = 0; v < voxels; v++) begin
        for (int c = 0; c < eff; c++) begin
          push_comp(pick_sample(), $urandom_range(0, 11) == 0);
          random_comps++;
        end
      end
      drain();
    end

    if (scalar_due.size() != 0)
      flag_mismatch($sformatf("%0d predicted words never arrived", scalar_due.size()));
    $display("Covered %0d components and %0d scalar words under %0d settings",
             comps_taken, words_seen, settings_run);
    $display("(%0d register writes, all four modes, lengths in and out of range)",
             reg_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vvs_pkg.sv
hw/rtl/vvs_iter.sv
hw/rtl/vvs_datapath.sv
hw/rtl/vvs_ctrl.sv
hw/rtl/vector_voxel_to_scalar_core.sv
bench/tb.sv
